// File: src/b64d_pkg.sv
// Shared types, constants and the character map of the base64 stream decoder.
// No dependencies; the front, queue, back and top level import it.
`default_nettype none

package b64d_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

  // Work handed from the front to the back: up to three bytes of one group.
  typedef struct packed {
    logic [23:0] word;      // bytes, first byte in the top eight bits
    logic [1:0]  nres;      // number of results, 1 to 3
    logic        has_byte;  // 0 for the empty end marker
    logic        msg_end;   // the last result closes the message
    logic        bad;       // group held a character outside the alphabet
  } job_t;

  typedef struct packed {
    logic ok;
    logic [5:0] sextet;
  } sextet_t;

  function automatic sextet_t map_char(input logic [7:0] c);
    sextet_t r;
    r.ok     = 1'b1;
    r.sextet = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r.sextet = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.sextet = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/b64d_if.sv
// Handshake channels of the base64 stream decoder: input characters and results.
// No dependencies.
`default_nettype none

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       msg_last;

  modport source (output valid, output char_in, output msg_last, input ready);
  modport sink (input valid, input char_in, input msg_last, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       run_last;
  logic       message_end;
  logic       bad_char;

  modport source (output valid, output data_byte, output has_byte, output run_last,
                  output message_end, output bad_char, input ready);
  modport sink (input valid, input data_byte, input has_byte, input run_last,
                input message_end, input bad_char, output ready);
endinterface

`default_nettype wire

// File: src/b64d_front.sv
// Front of the decoder: accepts characters, gathers sextets, builds byte jobs.
// Depends on b64d_pkg and b64d_if.
`default_nettype none

module b64d_front (
  input  wire logic         clk,
  input  wire logic         rst,
  b64d_in_if.sink           in_ch,
  input  wire logic         q_full,
  output logic              push,
  output b64d_pkg::job_t    push_job
);
  import b64d_pkg::*;

  logic [17:0] sextet_acc;
  logic [1:0]  group_count;
  logic        pad_seen;
  logic        group_bad;

  logic [17:0] sextet_acc_next;
  logic [1:0]  group_count_next;
  logic        pad_seen_next;
  logic        group_bad_next;

  logic        accept;
  sextet_t     mapped;
  logic        bad_now;
  logic [17:0] acc_grown;

  // Bytes owed by a partial group at message end.
  function automatic job_t flush_job(input logic [17:0] acc, input logic [1:0] cnt,
                                     input logic bad);
    job_t j;
    j.word     = 24'd0;
    j.nres     = 2'd1;
    j.has_byte = 1'b1;
    j.msg_end  = 1'b1;
    j.bad      = bad;
    unique case (cnt)
      2'd2: j.word = {acc[11:0], 12'd0};
      2'd3: begin
        j.word = {acc, 6'd0};
        j.nres = 2'd2;
      end
      default: j.has_byte = 1'b0;
    endcase
    return j;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign mapped      = map_char(in_ch.char_in);
  assign bad_now     = group_bad || !mapped.ok;
  assign acc_grown   = {sextet_acc[11:0], mapped.sextet};

  always_comb begin
    sextet_acc_next  = sextet_acc;
    group_count_next = group_count;
    pad_seen_next    = pad_seen;
    group_bad_next   = group_bad;
    push             = 1'b0;
    push_job         = flush_job(sextet_acc, group_count, group_bad);
    if (accept) begin
      if (pad_seen || in_ch.char_in == CHAR_PAD) begin
        pad_seen_next = 1'b1;
        if (in_ch.msg_last) begin
          push = 1'b1;
          sextet_acc_next  = 18'd0;
          group_count_next = 2'd0;
          pad_seen_next    = 1'b0;
          group_bad_next   = 1'b0;
        end
      end else if (group_count == 2'd3) begin
        push              = 1'b1;
        push_job.word     = {sextet_acc, mapped.sextet};
        push_job.nres     = 2'd3;
        push_job.has_byte = 1'b1;
        push_job.msg_end  = in_ch.msg_last;
        push_job.bad      = bad_now;
        sextet_acc_next   = 18'd0;
        group_count_next  = 2'd0;
        group_bad_next    = 1'b0;
      end else if (in_ch.msg_last) begin
        push             = 1'b1;
        push_job         = flush_job(acc_grown, group_count + 2'd1, bad_now);
        sextet_acc_next  = 18'd0;
        group_count_next = 2'd0;
        group_bad_next   = 1'b0;
      end else begin
        sextet_acc_next  = acc_grown;
        group_count_next = group_count + 2'd1;
        group_bad_next   = bad_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_acc  <= 18'd0;
      group_count <= 2'd0;
      pad_seen    <= 1'b0;
      group_bad   <= 1'b0;
    end else begin
      sextet_acc  <= sextet_acc_next;
      group_count <= group_count_next;
      pad_seen    <= pad_seen_next;
      group_bad   <= group_bad_next;
    end
  end

endmodule

`default_nettype wire

// File: src/b64d_queue.sv
// Short job queue between the front and the back of the decoder.
// Depends on b64d_pkg.
`default_nettype none

module b64d_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64d_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output b64d_pkg::job_t       head_job
);
  import b64d_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full      = (fill == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (fill != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/b64d_back.sv
// Back of the decoder: pops jobs, sends one result per cycle unless stalled.
// Depends on b64d_pkg and b64d_if.
`default_nettype none

module b64d_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_not_empty,
  input  wire b64d_pkg::job_t  q_job,
  output logic                 pop,
  b64d_out_if.source           out_ch
);
  import b64d_pkg::*;

  job_t       job;
  logic       busy;
  logic [1:0] idx;
  logic       is_final;
  logic       out_take;

  assign is_final = (idx == job.nres - 2'd1);
  assign out_take = busy && out_ch.ready;
  assign pop      = q_not_empty && (!busy || (out_take && is_final));

  assign out_ch.valid       = busy;
  assign out_ch.has_byte    = job.has_byte;
  assign out_ch.run_last    = is_final;
  assign out_ch.message_end = job.msg_end && is_final;
  assign out_ch.bad_char    = job.bad;

  always_comb begin
    unique case (idx)
      2'd0:    out_ch.data_byte = job.word[23:16];
      2'd1:    out_ch.data_byte = job.word[15:8];
      default: out_ch.data_byte = job.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (out_take) begin
      if (is_final) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front, job queue and back.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back.
//
//   channel   dir  transaction  fields
//   in_ch     in   one char     char_in[7:0], msg_last
//   out_ch    out  one result   data_byte[7:0], has_byte, run_last, message_end, bad_char
//
// Rates: a character is taken every cycle while the job queue has room; a
// result is sent from the back's job register, loaded when its job is popped.
// The back sends one result per cycle while out_ch.ready is high, and four
// characters per group then keep the stream at one character per cycle.
// Reset (rst, synchronous) clears the group state, the queue and the back.
// Stalls: out_ch.ready low holds the current result; in_ch.ready drops only
// when the four-entry queue is full.
`default_nettype none

module base64_stream_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);
  import b64d_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic q_not_empty;
  job_t q_job;

  // Classify characters and build byte jobs.
  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouple the character side from the result side.
  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_job  (q_job)
  );

  // Spread each job over its results.
  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (q_job),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
